// ===== rtl/priority_actor_ready_scheduler_assert.svh =====
// ============================================================================
// priority_actor_ready_scheduler_assert.svh
// Assertion macros for the actor ready scheduler. Each macro collapses to
// nothing when SYNTH is defined.
// ============================================================================
`ifndef PRIORITY_ACTOR_READY_SCHEDULER_ASSERT_SVH
`define PRIORITY_ACTOR_READY_SCHEDULER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define PARS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PARS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PARS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PARS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/pars_pkg.sv =====
// ============================================================================
// pars_pkg
// Shared types and constants of the priority actor ready scheduler.
// ============================================================================
package pars_pkg;

    localparam int NUM_ACTORS  = 64;
    localparam int ACTOR_W     = 6;
    localparam int COUNT_W     = 16;
    localparam int BANDS       = 3;
    localparam int BAND_W      = 2;
    localparam int SLOT_W      = 6;
    localparam int FILL_W      = 7;
    localparam int STORE_DEPTH = BANDS * NUM_ACTORS;
    localparam int STORE_AW    = BAND_W + SLOT_W;
    localparam int SUM_W       = COUNT_W + 2;
    localparam int TOTAL_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FILL_W-1:0]  FIFO_FULL = FILL_W'(NUM_ACTORS);

    // Priority band codes
    localparam logic [BAND_W-1:0] BAND_HIGH = 2'd0;
    localparam logic [BAND_W-1:0] BAND_MED  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_LOW  = 2'd2;

    typedef enum logic [1:0] {
        FUNC_SEND = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_END  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FIFO = 2'd1,
        S_EXEC = 2'd2
    } t_state;

    // One actor row: claim bit and the three band counts
    typedef struct packed {
        logic                           claim;
        logic [BANDS-1:0][COUNT_W-1:0]  cnt;
    } t_row;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic pop_rd;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic any_ready;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/pars_ctrl.sv =====
// ============================================================================
// pars_ctrl
// Sequencer of the scheduler: takes a beat, waits for the memory reads and
// commits the item once the output register can take its result.
// ============================================================================
module pars_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_func,
    input  pars_pkg::t_sts    i_sts,
    output logic              o_in_stall,
    output pars_pkg::t_cmd    o_cmd
);

    pars_pkg::t_state r_state;
    pars_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pars_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            pars_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_func == pars_pkg::FUNC_POP && i_sts.any_ready) begin
                        n_state = pars_pkg::S_FIFO;
                    end else begin
                        n_state = pars_pkg::S_EXEC;
                    end
                end
            end
            pars_pkg::S_FIFO: begin
                // FIFO head is out: fetch that actor's row
                o_cmd.pop_rd = 1'b1;
                n_state      = pars_pkg::S_EXEC;
            end
            pars_pkg::S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = pars_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pars_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pars_dp.sv =====
// ============================================================================
// pars_dp
// Datapath of the scheduler: actor row memory, ready FIFO store, FIFO
// pointers, processed total and the output register.
// ============================================================================
module pars_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pars_pkg::t_cmd                    i_cmd,
    output pars_pkg::t_sts                    o_sts,
    input  logic [1:0]                        i_func,
    input  logic [pars_pkg::ACTOR_W-1:0]      i_actor_id,
    input  logic [pars_pkg::BAND_W-1:0]       i_band,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [1:0]                        o_status,
    output logic [pars_pkg::ACTOR_W-1:0]      o_actor_out,
    output logic [pars_pkg::COUNT_W-1:0]      o_drained_high,
    output logic [pars_pkg::COUNT_W-1:0]      o_drained_medium,
    output logic [pars_pkg::COUNT_W-1:0]      o_drained_low,
    output logic                              o_requeued,
    output logic [pars_pkg::BAND_W-1:0]       o_requeue_band,
    output logic [pars_pkg::TOTAL_W-1:0]      o_processed_total
);

    // Captured item
    logic [1:0]                       r_func;
    logic [pars_pkg::ACTOR_W-1:0]     r_actor;
    logic [pars_pkg::BAND_W-1:0]      r_band;
    logic [pars_pkg::BAND_W-1:0]      r_pop_band;
    logic                             r_pop_found;

    // Memories and their read registers
    pars_pkg::t_row                   r_row_mem [pars_pkg::NUM_ACTORS];
    logic [pars_pkg::NUM_ACTORS-1:0]  r_row_vld;
    pars_pkg::t_row                   r_row_rd;
    logic                             r_row_rd_vld;
    logic [pars_pkg::ACTOR_W-1:0]     r_store [pars_pkg::STORE_DEPTH];
    logic [pars_pkg::ACTOR_W-1:0]     r_fifo_q;

    // FIFO pointers and total
    logic [pars_pkg::SLOT_W-1:0]      r_head [pars_pkg::BANDS];
    logic [pars_pkg::FILL_W-1:0]      r_fill [pars_pkg::BANDS];
    logic [pars_pkg::TOTAL_W-1:0]     r_total;

    // Output register
    logic                             r_out_vld;
    pars_pkg::t_status                r_out_status;
    logic [pars_pkg::ACTOR_W-1:0]     r_out_actor;
    logic [pars_pkg::BANDS-1:0][pars_pkg::COUNT_W-1:0] r_out_drained;
    logic                             r_out_req;
    logic [pars_pkg::BAND_W-1:0]      r_out_req_band;

    // Combinational
    logic [pars_pkg::BAND_W-1:0]      sel_band;
    logic                             any_ready;
    logic [pars_pkg::ACTOR_W-1:0]     row_raddr;
    logic [pars_pkg::ACTOR_W-1:0]     row_waddr;
    pars_pkg::t_row                   row;
    pars_pkg::t_row                   n_row;
    logic                             row_we;
    logic                             push;
    logic [pars_pkg::BAND_W-1:0]      push_band;
    logic [pars_pkg::SLOT_W-1:0]      push_slot;
    logic                             pop;
    pars_pkg::t_status                status;
    logic [pars_pkg::ACTOR_W-1:0]     actor_out;
    logic [pars_pkg::BANDS-1:0][pars_pkg::COUNT_W-1:0] drained;
    logic                             req;
    logic [pars_pkg::SUM_W-1:0]       sum;
    logic [pars_pkg::BAND_W-1:0]      hi_band;

    // Pick the highest non-empty ready FIFO
    always_comb begin
        sel_band = pars_pkg::BAND_LOW;
        if (r_fill[pars_pkg::BAND_MED] != '0) begin
            sel_band = pars_pkg::BAND_MED;
        end
        if (r_fill[pars_pkg::BAND_HIGH] != '0) begin
            sel_band = pars_pkg::BAND_HIGH;
        end
    end

    assign any_ready = (r_fill[pars_pkg::BAND_HIGH] != '0) ||
                       (r_fill[pars_pkg::BAND_MED] != '0)  ||
                       (r_fill[pars_pkg::BAND_LOW] != '0);

    assign o_sts.any_ready = any_ready;
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;

    assign row_raddr = i_cmd.pop_rd ? r_fifo_q : i_actor_id;
    assign row_waddr = (r_func == pars_pkg::FUNC_POP) ? r_fifo_q : r_actor;
    assign row       = r_row_rd_vld ? r_row_rd : '0;
    assign push_slot = r_head[push_band] + r_fill[push_band][pars_pkg::SLOT_W-1:0];

    // Highest band with pending messages, for end of turn
    always_comb begin
        hi_band = pars_pkg::BAND_LOW;
        if (row.cnt[pars_pkg::BAND_MED] != '0) begin
            hi_band = pars_pkg::BAND_MED;
        end
        if (row.cnt[pars_pkg::BAND_HIGH] != '0) begin
            hi_band = pars_pkg::BAND_HIGH;
        end
    end

    // Work out the item's effect on the row, the FIFOs and the result
    always_comb begin
        n_row     = row;
        row_we    = 1'b0;
        push      = 1'b0;
        push_band = r_band;
        pop       = 1'b0;
        status    = pars_pkg::ST_DONE;
        actor_out = r_actor;
        drained   = '0;
        req       = 1'b0;
        sum       = '0;
        case (r_func)
            pars_pkg::FUNC_SEND: begin
                if (row.cnt[r_band] == pars_pkg::COUNT_MAX) begin
                    status = pars_pkg::ST_FULL;
                end else begin
                    n_row.cnt[r_band] = row.cnt[r_band] + 1'b1;
                    row_we            = 1'b1;
                    if (!row.claim && r_fill[r_band] != pars_pkg::FIFO_FULL) begin
                        push        = 1'b1;
                        n_row.claim = 1'b1;
                        req         = 1'b1;
                    end
                end
            end
            pars_pkg::FUNC_POP: begin
                if (r_pop_found) begin
                    pop       = 1'b1;
                    actor_out = r_fifo_q;
                    drained   = row.cnt;
                    n_row.cnt = '0;
                    row_we    = 1'b1;
                    sum       = pars_pkg::SUM_W'(row.cnt[pars_pkg::BAND_HIGH]) +
                                pars_pkg::SUM_W'(row.cnt[pars_pkg::BAND_MED]) +
                                pars_pkg::SUM_W'(row.cnt[pars_pkg::BAND_LOW]);
                end else begin
                    status = pars_pkg::ST_EMPTY;
                end
            end
            pars_pkg::FUNC_END: begin
                row_we      = 1'b1;
                n_row.claim = 1'b0;
                push_band   = hi_band;
                if (row.cnt != '0 && r_fill[hi_band] != pars_pkg::FIFO_FULL) begin
                    push        = 1'b1;
                    n_row.claim = 1'b1;
                    req         = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Capture the beat and issue the memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func      <= i_func;
            r_actor     <= i_actor_id;
            r_band      <= (i_band > pars_pkg::BAND_LOW) ? pars_pkg::BAND_LOW : i_band;
            r_pop_band  <= sel_band;
            r_pop_found <= any_ready;
            r_fifo_q    <= r_store[{sel_band, r_head[sel_band]}];
        end
        if (i_cmd.capture || i_cmd.pop_rd) begin
            r_row_rd     <= r_row_mem[row_raddr];
            r_row_rd_vld <= r_row_vld[row_raddr];
        end
    end

    // Write back the row and the appended FIFO entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && row_we) begin
            r_row_mem[row_waddr] <= n_row;
        end
        if (i_cmd.commit && push) begin
            r_store[{push_band, push_slot}] <= r_actor;
        end
    end

    // Row valid bits, FIFO pointers and total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_total   <= '0;
            for (int b = 0; b < pars_pkg::BANDS; b++) begin
                r_head[b] <= '0;
                r_fill[b] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (row_we) begin
                r_row_vld[row_waddr] <= 1'b1;
            end
            if (push) begin
                r_fill[push_band] <= r_fill[push_band] + 1'b1;
            end
            if (pop) begin
                r_head[r_pop_band] <= r_head[r_pop_band] + 1'b1;
                r_fill[r_pop_band] <= r_fill[r_pop_band] - 1'b1;
            end
            r_total <= r_total + pars_pkg::TOTAL_W'(sum);
        end
    end

    // Output valid: set on commit, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status   <= status;
            r_out_actor    <= actor_out;
            r_out_drained  <= drained;
            r_out_req      <= req;
            r_out_req_band <= req ? push_band : pars_pkg::BAND_HIGH;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_status          = r_out_status;
    assign o_actor_out       = r_out_actor;
    assign o_drained_high    = r_out_drained[pars_pkg::BAND_HIGH];
    assign o_drained_medium  = r_out_drained[pars_pkg::BAND_MED];
    assign o_drained_low     = r_out_drained[pars_pkg::BAND_LOW];
    assign o_requeued        = r_out_req;
    assign o_requeue_band    = r_out_req_band;
    assign o_processed_total = r_total;

endmodule

// ===== rtl/priority_actor_ready_scheduler.sv =====
// ============================================================================
// priority_actor_ready_scheduler
// Strict-priority ready scheduler for 64 actors with three pending-message
// bands and a claim bit per actor.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per beat:
//   send a message, pop the next ready actor, or end an actor's turn.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result
//   beat per command, in order.
//   Sequence: send and end-turn register the actor row read at accept and
//   write it back from that read; pop first registers the read of the ready
//   FIFO store at accept, then the actor row read, before the write-back.
//   Commands do not overlap: a new command is taken only after the last one
//   is written back, though it is taken while the last result still waits.
//   Reset: synchronous, active low. All rows read as unclaimed with zero
//   counts, all ready FIFOs are empty and the processed total is zero; no
//   clearing pass is needed, commands are taken right after reset.
//   Receiver stall: the result stays in the output register; the block can
//   accept one further command and holds it at write-back until the output
//   register is free.
// ============================================================================
`include "priority_actor_ready_scheduler_assert.svh"

module priority_actor_ready_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic [pars_pkg::ACTOR_W-1:0]      i_actor_id,
    input  logic [pars_pkg::BAND_W-1:0]       i_band,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [pars_pkg::ACTOR_W-1:0]      o_actor_out,
    output logic [pars_pkg::COUNT_W-1:0]      o_drained_high,
    output logic [pars_pkg::COUNT_W-1:0]      o_drained_medium,
    output logic [pars_pkg::COUNT_W-1:0]      o_drained_low,
    output logic                              o_requeued,
    output logic [pars_pkg::BAND_W-1:0]       o_requeue_band,
    output logic [pars_pkg::TOTAL_W-1:0]      o_processed_total
);

    pars_pkg::t_cmd cmd;
    pars_pkg::t_sts sts;

    // Sequencer
    pars_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Storage and compute
    pars_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_func            (i_func),
        .i_actor_id        (i_actor_id),
        .i_band            (i_band),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_actor_out       (o_actor_out),
        .o_drained_high    (o_drained_high),
        .o_drained_medium  (o_drained_medium),
        .o_drained_low     (o_drained_low),
        .o_requeued        (o_requeued),
        .o_requeue_band    (o_requeue_band),
        .o_processed_total (o_processed_total)
    );

    // Checks
    `PARS_ASSERT_IMPLY(a_commit_free, i_clk, i_rst_n, cmd.commit, sts.out_free, "commit while output register busy")
    `PARS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second beat taken before write-back")
    `PARS_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, cmd.commit, o_out_valid, "committed result not presented")
    `PARS_ASSERT_IMPLY(a_req_done, i_clk, i_rst_n, o_out_valid && o_requeued, o_status == pars_pkg::ST_DONE, "requeue reported with error status")

endmodule
